// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MRF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define MRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mrf_pkg.sv =====
`default_nettype none
package mrf_pkg;
	localparam int MAX_COLUMNS_DEF = 64;
	localparam int MAX_ROWS_DEF    = 256;
	localparam int ROW_W           = 64;
	localparam int ROW_IW          = 6;
	localparam int CFG_W           = 7;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
	localparam int OUT_TDATA_W     = 104;

	localparam logic KIND_MASK = 1'b0;
	localparam logic KIND_RECT = 1'b1;

	// result payload, lowest field last
	typedef struct packed {
		logic        pad;
		logic        overflow;
		logic [6:0]  rect_width;
		logic [8:0]  rect_height;
		logic [5:0]  rect_left;
		logic [7:0]  rect_top;
		logic [63:0] isolated_mask;
		logic [7:0]  row_index;
	} out_item_t;
endpackage
`default_nettype wire

// ===== sv/maximal_rectangle_finder_unit.sv =====
// Finds the first largest all-ones rectangle (area above 1) in a grid streamed one row per
// transaction, and emits a mask of isolated set cells for each row, one row late. Each row
// first sweeps the column height memory over all MAX_COLUMNS entries to update heights, then
// runs two monotonic-stack sweeps over the clamped column count cols, with at most 2*cols
// pops in all. Every update reads and then writes the simple dual-port height memory, and
// each push or pop waits on the registered read of the stack memory. The block takes no new
// row while one is in work. On the final row it gives up to three results, the last one with
// tlast. columns_in_use is to be written on the cfg channel only while idle; the block does
// not enforce this. 0 counts as 1, values above MAX_COLUMNS as MAX_COLUMNS.
`default_nettype none
module maximal_rectangle_finder_unit #(
	parameter int MAX_COLUMNS = mrf_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = mrf_pkg::MAX_ROWS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [mrf_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [mrf_pkg::ROW_W-1:0]       s_tdata,  // row_bits
	input  wire logic                            s_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// row_index, isolated_mask, rect_top, rect_left, rect_height, rect_width, overflow, pad
	output logic [mrf_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic                                 m_tuser,  // kind
	output logic                                 m_tlast
);
	import mrf_pkg::*;

	localparam int CIW = $clog2(MAX_COLUMNS);
	localparam int CWW = $clog2(MAX_COLUMNS + 1);
	localparam int HW  = $clog2(MAX_ROWS + 1);
	localparam int RW  = HW;
	localparam int AW  = HW + CWW;

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b000_0000_0001,
		ST_EMIT_PREV = 11'b000_0000_0010,
		ST_UPD_RD    = 11'b000_0000_0100,
		ST_UPD_WR    = 11'b000_0000_1000,
		ST_R_RD      = 11'b000_0001_0000,
		ST_R_CMP     = 11'b000_0010_0000,
		ST_L_RD      = 11'b000_0100_0000,
		ST_L_CMP     = 11'b000_1000_0000,
		ST_AREA      = 11'b001_0000_0000,
		ST_EMIT_CUR  = 11'b010_0000_0000,
		ST_EMIT_RECT = 11'b100_0000_0000
	} state_t;

	state_t                 state_q;
	logic [CFG_W-1:0]       cfg_q;
	logic [CIW-1:0]         j_q;
	logic [CWW-1:0]         sp_q;
	logic [CWW-1:0]         cols_q;
	logic [ROW_W-1:0]       row_q;
	logic                   last_q;
	logic [ROW_W-1:0]       prev_q;
	logic [ROW_W-1:0]       rbp_q;
	logic [RW-1:0]          cnt_q;
	logic                   ovf_q;
	logic [MAX_COLUMNS-1:0] hvld_q;
	logic                   hv_q;
	logic [CIW-1:0]         l_q;
	logic [CIW-1:0]         r_q;
	logic [HW-1:0]          hc_q;
	logic [RW-1:0]          best_top_q;
	logic [CIW-1:0]         best_left_q;
	logic [HW-1:0]          best_h_q;
	logic [CWW-1:0]         best_w_q;
	logic [AW-1:0]          best_area_q;
	out_item_t              out_q;
	logic                   out_kind_q;
	logic                   out_last_q;
	logic                   m_valid_q;

	logic [HW-1:0]     h_rdata, hcur, hnew;
	logic [CIW+HW-1:0] stk_rdata;
	logic [CIW-1:0]    rgt_rdata, top_idx;
	logic [HW-1:0]     top_h;
	logic              pop, out_free, emit, h_we, stk_we, rgt_we;
	logic [CIW-1:0]    rgt_wdata, stk_raddr;
	logic [CWW-1:0]    cols_eff, w_c;
	logic [ROW_W-1:0]  colmask;
	logic [AW-1:0]     area_c;
	logic [RW-1:0]     top_c;
	out_item_t         rect_c;

	function automatic logic [ROW_W-1:0] iso_of(input logic [ROW_W-1:0] up,
			input logic [ROW_W-1:0] mid, input logic [ROW_W-1:0] down);
		return mid & ~(mid << 1) & ~(mid >> 1) & ~up & ~down;
	endfunction

	function automatic out_item_t mask_item(input logic [RW-1:0] row,
			input logic [ROW_W-1:0] mask, input logic ovf);
		out_item_t it;
		it               = '0;
		it.row_index     = 8'(row);
		it.isolated_mask = mask;
		it.overflow      = ovf;
		return it;
	endfunction

	// clamp the column count and build the column mask
	always_comb begin
		if (cfg_q == '0) begin
			cols_eff = CWW'(1);
		end else if (32'(cfg_q) > 32'(MAX_COLUMNS)) begin
			cols_eff = CWW'(MAX_COLUMNS);
		end else begin
			cols_eff = CWW'(cfg_q);
		end
		for (int i = 0; i < ROW_W; i++) begin
			colmask[i] = (i < int'(cols_eff));
		end
	end

	always_comb begin
		rect_c             = '0;
		rect_c.rect_top    = 8'(best_top_q);
		rect_c.rect_left   = 6'(best_left_q);
		rect_c.rect_height = 9'(best_h_q);
		rect_c.rect_width  = 7'(best_w_q);
		rect_c.overflow    = ovf_q;
	end

	assign hcur      = hv_q ? h_rdata : '0;
	assign top_idx   = stk_rdata[CIW+HW-1:HW];
	assign top_h     = stk_rdata[HW-1:0];
	assign pop       = (sp_q != '0) && (top_h >= hcur);
	assign out_free  = !m_valid_q || m_tready;
	assign emit      = out_free && (state_q inside {ST_EMIT_PREV, ST_EMIT_CUR, ST_EMIT_RECT});
	assign stk_raddr = CIW'(sp_q - CWW'(1));

	assign hnew = row_q[ROW_IW'(j_q)] ?
		((hcur < HW'(MAX_ROWS)) ? hcur + HW'(1) : hcur) : '0;
	assign h_we      = (state_q == ST_UPD_WR);
	assign stk_we    = ((state_q == ST_R_CMP) || (state_q == ST_L_CMP)) && !pop;
	assign rgt_we    = (state_q == ST_R_CMP) && !pop;
	assign rgt_wdata = (sp_q == '0) ? CIW'(cols_q - CWW'(1)) : top_idx - CIW'(1);

	assign w_c    = CWW'(r_q) - CWW'(l_q) + CWW'(1);
	assign area_c = AW'(w_c) * AW'(hc_q);
	assign top_c  = cnt_q + RW'(1) - RW'(hc_q);

	mrf_ram #(.W(HW), .D(MAX_COLUMNS)) u_heights (
		.clk   (clk),
		.we    (h_we),
		.waddr (j_q),
		.wdata (hnew),
		.raddr (j_q),
		.rdata (h_rdata)
	);

	// stack entries hold column index and height
	mrf_ram #(.W(CIW + HW), .D(MAX_COLUMNS)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (sp_q[CIW-1:0]),
		.wdata ({j_q, hcur}),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	mrf_ram #(.W(CIW), .D(MAX_COLUMNS)) u_right (
		.clk   (clk),
		.we    (rgt_we),
		.waddr (j_q),
		.wdata (rgt_wdata),
		.raddr (j_q),
		.rdata (rgt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= CFG_RESET;
			j_q         <= '0;
			sp_q        <= '0;
			cols_q      <= '0;
			row_q       <= '0;
			last_q      <= 1'b0;
			prev_q      <= '0;
			rbp_q       <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			hvld_q      <= '0;
			hv_q        <= 1'b0;
			l_q         <= '0;
			r_q         <= '0;
			hc_q        <= '0;
			best_top_q  <= '0;
			best_left_q <= '0;
			best_h_q    <= '0;
			best_w_q    <= '0;
			best_area_q <= '0;
			out_q       <= '0;
			out_kind_q  <= KIND_MASK;
			out_last_q  <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			hv_q <= hvld_q[j_q];
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				cfg_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						row_q  <= s_tdata & colmask;
						last_q <= s_tlast;
						cols_q <= cols_eff;
						j_q    <= '0;
						if (32'(cnt_q) >= 32'(MAX_ROWS)) begin
							ovf_q   <= 1'b1;
							state_q <= s_tlast ? ST_EMIT_CUR : ST_IDLE;
						end else if (cnt_q != '0) begin
							state_q <= ST_EMIT_PREV;
						end else begin
							state_q <= ST_UPD_RD;
						end
					end
				end
				ST_EMIT_PREV: begin
					if (out_free) begin
						out_q      <= mask_item(cnt_q - RW'(1), iso_of(rbp_q, prev_q, row_q), ovf_q);
						out_kind_q <= KIND_MASK;
						out_last_q <= 1'b0;
						state_q    <= ST_UPD_RD;
					end
				end
				ST_UPD_RD: begin
					state_q <= ST_UPD_WR;
				end
				ST_UPD_WR: begin
					hvld_q[j_q] <= 1'b1;
					if (j_q == CIW'(MAX_COLUMNS - 1)) begin
						j_q     <= CIW'(cols_q - CWW'(1));
						sp_q    <= '0;
						state_q <= ST_R_RD;
					end else begin
						j_q     <= j_q + CIW'(1);
						state_q <= ST_UPD_RD;
					end
				end
				ST_R_RD: begin
					state_q <= ST_R_CMP;
				end
				ST_R_CMP: begin
					if (pop) begin
						sp_q    <= sp_q - CWW'(1);
						state_q <= ST_R_RD;
					end else if (j_q == '0) begin
						sp_q    <= '0;
						state_q <= ST_L_RD;
					end else begin
						sp_q    <= sp_q + CWW'(1);
						j_q     <= j_q - CIW'(1);
						state_q <= ST_R_RD;
					end
				end
				ST_L_RD: begin
					state_q <= ST_L_CMP;
				end
				ST_L_CMP: begin
					if (pop) begin
						sp_q    <= sp_q - CWW'(1);
						state_q <= ST_L_RD;
					end else begin
						sp_q    <= sp_q + CWW'(1);
						l_q     <= (sp_q == '0) ? '0 : top_idx + CIW'(1);
						r_q     <= rgt_rdata;
						hc_q    <= hcur;
						state_q <= ST_AREA;
					end
				end
				ST_AREA: begin
					// strict improvement only, single cells never count
					if (area_c > best_area_q && area_c != AW'(1)) begin
						best_area_q <= area_c;
						best_h_q    <= hc_q;
						best_w_q    <= w_c;
						best_top_q  <= top_c;
						best_left_q <= l_q;
					end
					if (j_q == CIW'(cols_q - CWW'(1))) begin
						rbp_q   <= prev_q;
						prev_q  <= row_q;
						cnt_q   <= cnt_q + RW'(1);
						state_q <= last_q ? ST_EMIT_CUR : ST_IDLE;
					end else begin
						j_q     <= j_q + CIW'(1);
						state_q <= ST_L_RD;
					end
				end
				ST_EMIT_CUR: begin
					if (out_free) begin
						out_q      <= mask_item(cnt_q - RW'(1), iso_of(rbp_q, prev_q, '0), ovf_q);
						out_kind_q <= KIND_MASK;
						out_last_q <= (best_area_q == '0);
						if (best_area_q == '0) begin
							state_q     <= ST_IDLE;
							prev_q      <= '0;
							rbp_q       <= '0;
							cnt_q       <= '0;
							ovf_q       <= 1'b0;
							hvld_q      <= '0;
						end else begin
							state_q <= ST_EMIT_RECT;
						end
					end
				end
				ST_EMIT_RECT: begin
					if (out_free) begin
						out_q             <= rect_c;
						out_kind_q        <= KIND_RECT;
						out_last_q        <= 1'b1;
						state_q           <= ST_IDLE;
						prev_q            <= '0;
						rbp_q             <= '0;
						cnt_q             <= '0;
						ovf_q             <= 1'b0;
						hvld_q            <= '0;
						best_top_q        <= '0;
						best_left_q       <= '0;
						best_h_q          <= '0;
						best_w_q          <= '0;
						best_area_q       <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = out_q;
	assign m_tuser   = out_kind_q;
	assign m_tlast   = out_last_q;
endmodule
`default_nettype wire

// ===== sv/mrf_ram.sv =====
`default_nettype none
module mrf_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/mrf_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module mrf_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic [mrf_pkg::ROW_W-1:0]        s_tdata,
	input wire logic                             s_tlast,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [mrf_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input wire logic                             m_tuser,
	input wire logic                             m_tlast
);
	import mrf_pkg::*;

	out_item_t item;
	logic      rect_ok;
	assign item    = out_item_t'(m_tdata);
	assign rect_ok = (item.rect_width != '0) && (item.rect_height != '0);

	// an offered row waits unchanged until it is taken
	`MRF_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata) && $stable(s_tlast), "offered row changed")
	`MRF_ASSERT(a_rect_is_last, m_tvalid && m_tuser == KIND_RECT |-> m_tlast, "rect without tlast")
	`MRF_ASSERT(a_rect_nonzero, m_tvalid && m_tuser == KIND_RECT |-> rect_ok, "empty rect sent")
	`MRF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
endmodule

bind maximal_rectangle_finder_unit mrf_checker u_mrf_checker (.*);
`default_nettype wire
